### hw/rtl/hmtq_pkg.sv
// Package for the heightmap triangle height query block.
// Field widths, register and command codes, controller/datapath structs.
// No dependencies.
`default_nettype none

package hmtq_pkg;

  localparam int MAX_GRID_DIM_DEF  = 256;
  localparam int FRACTION_BITS_DEF = 8;

  localparam int DIM_W     = 9;
  localparam int SIZE_W    = 11;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;
  localparam int VIDX_W    = 16;
  localparam int HEIGHT_W  = 24;
  localparam int POS_W     = 32;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLUMNS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_SIZE    = 2'd2;

  // reset values of the registers
  localparam logic [DIM_W-1:0]  GRID_COLUMNS_RST = 9'd256;
  localparam logic [DIM_W-1:0]  GRID_ROWS_RST    = 9'd256;
  localparam logic [SIZE_W-1:0] CELL_SIZE_RST    = 11'd1;

  // word kinds
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef enum logic [1:0] {
    CORNER_A = 2'd0,
    CORNER_B = 2'd1,
    CORNER_C = 2'd2,
    CORNER_D = 2'd3
  } corner_e;

  typedef enum logic [1:0] {
    MUL_E1_LO = 2'd0,
    MUL_E1_HI = 2'd1,
    MUL_E2_LO = 2'd2,
    MUL_E2_HI = 2'd3
  } mul_step_e;

  typedef struct packed {
    logic      load;
    logic      wr_en;
    logic      div_start;
    logic      div_step;
    logic      cell_ux;
    logic      cell_off;
    logic      addr_calc;
    logic      rd_en;
    corner_e   corner;
    logic      tri_setup;
    logic      mul_en;
    mul_step_e mul_step;
    logic      round;
    logic      out_load;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic is_query;
  } status_t;

endpackage

`default_nettype wire

### hw/rtl/hmtq_ram.sv
// Generic single-port RAM, registered read.
// No dependencies.
`default_nettype none

module hmtq_ram #(
  parameter int Width = 24,
  parameter int Depth = 65536
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

`default_nettype wire

### hw/rtl/hmtq_ctrl.sv
// Controller FSM for the height query block: sequences the datapath.
// Depends on hmtq_pkg.
`default_nettype none

module hmtq_ctrl import hmtq_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  input  wire status_t status_i,
  output cmd_t         cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_DIV,
    ST_UX,
    ST_OFF,
    ST_ADDR,
    ST_RA,
    ST_RB,
    ST_RC,
    ST_RD,
    ST_RWAIT,
    ST_SETUP,
    ST_M0,
    ST_M1,
    ST_M2,
    ST_M3,
    ST_MACC,
    ST_RND,
    ST_EMIT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   can_load;

  assign can_load    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (status_i.is_query) begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_DIV;
        end else begin
          cmd_o.wr_en = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_done) begin
          state_d = ST_UX;
        end
      end
      ST_UX: begin
        cmd_o.cell_ux = 1'b1;
        state_d       = ST_OFF;
      end
      ST_OFF: begin
        cmd_o.cell_off = 1'b1;
        state_d        = ST_ADDR;
      end
      ST_ADDR: begin
        cmd_o.addr_calc = 1'b1;
        state_d         = ST_RA;
      end
      ST_RA: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.corner = CORNER_A;
        state_d      = ST_RB;
      end
      ST_RB: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.corner = CORNER_B;
        state_d      = ST_RC;
      end
      ST_RC: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.corner = CORNER_C;
        state_d      = ST_RD;
      end
      ST_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.corner = CORNER_D;
        state_d      = ST_RWAIT;
      end
      ST_RWAIT: state_d = ST_SETUP;
      ST_SETUP: begin
        cmd_o.tri_setup = 1'b1;
        state_d         = ST_M0;
      end
      ST_M0: begin
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_step = MUL_E1_LO;
        state_d        = ST_M1;
      end
      ST_M1: begin
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_step = MUL_E1_HI;
        state_d        = ST_M2;
      end
      ST_M2: begin
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_step = MUL_E2_LO;
        state_d        = ST_M3;
      end
      ST_M3: begin
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_step = MUL_E2_HI;
        state_d        = ST_MACC;
      end
      ST_MACC: state_d = ST_RND;
      ST_RND: begin
        cmd_o.round = 1'b1;
        state_d     = ST_EMIT;
      end
      ST_EMIT: begin
        if (can_load) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/hmtq_dp.sv
// Datapath for the height query block: config registers, divider lanes,
// cell/offset math, height store, triangle interpolation, output register.
// Depends on hmtq_pkg and hmtq_ram.
`default_nettype none

module hmtq_dp import hmtq_pkg::*; #(
  parameter int MaxGridDim   = MAX_GRID_DIM_DEF,
  parameter int FractionBits = FRACTION_BITS_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_valid_i,
  input  wire logic [CFG_IDX_W-1:0]       cfg_index_i,
  input  wire logic [CFG_W-1:0]           cfg_data_i,
  input  wire logic                       kind_i,
  input  wire logic [VIDX_W-1:0]          vertex_index_i,
  input  wire logic signed [HEIGHT_W-1:0] vertex_height_i,
  input  wire logic signed [POS_W-1:0]    pos_x_i,
  input  wire logic signed [POS_W-1:0]    pos_z_i,
  input  wire cmd_t                       cmd_i,
  output status_t                         status_o,
  output logic signed [HEIGHT_W-1:0]      height_o
);

  localparam int DW    = $clog2(MaxGridDim + 1);
  localparam int CLW   = $clog2(MaxGridDim);
  localparam int Depth = MaxGridDim * MaxGridDim;
  localparam int AW    = $clog2(Depth);
  localparam int BW    = DW + SIZE_W;
  localparam int CXB   = BW + FractionBits - 1;
  localparam int CW    = ((CXB > POS_W) ? CXB : POS_W) + 2;
  localparam int UW    = CW + 1;
  localparam int XW    = UW + 1;
  localparam int MW    = XW + 1;
  localparam int L     = MW / 2;
  localparam int HW    = MW - L;
  localparam int EW    = HEIGHT_W + 1;
  localparam int SW    = EW + MW + 2;
  localparam int CNTW  = $clog2(CW + 1);

  localparam logic signed [XW:0]   OneSum = (XW + 1)'(1) << FractionBits;
  localparam logic signed [MW-1:0] OneM   = MW'(1) << FractionBits;
  localparam logic signed [SW-1:0] Half   = SW'(1) << (FractionBits - 1);
  localparam logic signed [SW-1:0] HMax   = SW'((1 << (HEIGHT_W - 1)) - 1);
  localparam logic signed [SW-1:0] HMin   = -SW'(1 << (HEIGHT_W - 1));

  // configuration
  logic [DIM_W-1:0]  cols_q, rows_q;
  logic [SIZE_W-1:0] size_q;
  logic [DW-1:0]     cols_c, rows_c;
  logic [SIZE_W-1:0] size_c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= GRID_COLUMNS_RST;
      rows_q <= GRID_ROWS_RST;
      size_q <= CELL_SIZE_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_GRID_COLUMNS: cols_q <= cfg_data_i[DIM_W-1:0];
        CFG_GRID_ROWS:    rows_q <= cfg_data_i[DIM_W-1:0];
        CFG_CELL_SIZE:    size_q <= cfg_data_i[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (cols_q < DIM_W'(2))                 cols_c = DW'(2);
    else if (32'(cols_q) > MaxGridDim)      cols_c = DW'(MaxGridDim);
    else                                    cols_c = DW'(cols_q);
    if (rows_q < DIM_W'(2))                 rows_c = DW'(2);
    else if (32'(rows_q) > MaxGridDim)      rows_c = DW'(MaxGridDim);
    else                                    rows_c = DW'(rows_q);
    size_c = (size_q == '0) ? SIZE_W'(1) : size_q;
  end

  // input word
  logic                       kind_q;
  logic [VIDX_W-1:0]          vidx_q;
  logic signed [HEIGHT_W-1:0] vh_q;
  logic signed [POS_W-1:0]    px_q, pz_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= kind_i;
      vidx_q <= vertex_index_i;
      vh_q   <= vertex_height_i;
      px_q   <= pos_x_i;
      pz_q   <= pos_z_i;
    end
  end

  // shifted coordinates
  logic [BW-1:0]          span_x, span_z;
  logic [CW-1:0]          sh_x, sh_z;
  logic signed [CW-1:0]   cx, cz;
  logic [DW-1:0]          cols_m1, rows_m1;

  assign cols_m1 = cols_c - DW'(1);
  assign rows_m1 = rows_c - DW'(1);
  assign span_x  = BW'(cols_m1) * BW'(size_c);
  assign span_z  = BW'(rows_m1) * BW'(size_c);
  assign sh_x    = CW'(span_x) << (FractionBits - 1);
  assign sh_z    = CW'(span_z) << (FractionBits - 1);
  assign cx      = $signed(sh_x) + CW'(px_q);
  assign cz      = $signed(sh_z) - CW'(pz_q);

  // restoring divider, x and z lanes, one quotient bit per cycle
  logic [CW-1:0]     dvd_x_q, dvd_z_q;
  logic [SIZE_W-1:0] rem_x_q, rem_z_q;
  logic              neg_x_q, neg_z_q;
  logic [CNTW-1:0]   cnt_q;
  logic [SIZE_W:0]   rsx, rsz, subx, subz;
  logic              fit_x, fit_z;

  assign rsx   = {rem_x_q, dvd_x_q[CW-1]};
  assign rsz   = {rem_z_q, dvd_z_q[CW-1]};
  assign fit_x = (rsx >= {1'b0, size_c});
  assign fit_z = (rsz >= {1'b0, size_c});
  assign subx  = rsx - {1'b0, size_c};
  assign subz  = rsz - {1'b0, size_c};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.div_start) begin
      cnt_q <= CNTW'(CW);
    end else if (cmd_i.div_step && cnt_q != '0) begin
      cnt_q <= cnt_q - CNTW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      neg_x_q <= cx[CW-1];
      neg_z_q <= cz[CW-1];
      dvd_x_q <= cx[CW-1] ? -cx : cx;
      dvd_z_q <= cz[CW-1] ? -cz : cz;
      rem_x_q <= '0;
      rem_z_q <= '0;
    end else if (cmd_i.div_step && cnt_q != '0) begin
      dvd_x_q <= {dvd_x_q[CW-2:0], fit_x};
      dvd_z_q <= {dvd_z_q[CW-2:0], fit_z};
      rem_x_q <= fit_x ? subx[SIZE_W-1:0] : rsx[SIZE_W-1:0];
      rem_z_q <= fit_z ? subz[SIZE_W-1:0] : rsz[SIZE_W-1:0];
    end
  end

  // floored quotient
  logic [UW-1:0]        qe_x, qe_z;
  logic signed [UW-1:0] ux_q, uz_q;

  assign qe_x = {1'b0, dvd_x_q} + UW'(neg_x_q && rem_x_q != '0);
  assign qe_z = {1'b0, dvd_z_q} + UW'(neg_z_q && rem_z_q != '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.cell_ux) begin
      ux_q <= neg_x_q ? -$signed(qe_x) : $signed(qe_x);
      uz_q <= neg_z_q ? -$signed(qe_z) : $signed(qe_z);
    end
  end

  // cell clamp and offsets
  logic signed [UW-1:0] cr_x, cr_z, lim_x, lim_z, cs_x, cs_z;
  logic [CLW-1:0]       col_c, row_c, col_q, row_q;
  logic signed [XW-1:0] dx_q, dz_q;

  assign cr_x  = ux_q >>> FractionBits;
  assign cr_z  = uz_q >>> FractionBits;
  assign lim_x = $signed(UW'(cols_c - DW'(2)));
  assign lim_z = $signed(UW'(rows_c - DW'(2)));

  always_comb begin
    if (cr_x[UW-1])        cs_x = '0;
    else if (cr_x > lim_x) cs_x = lim_x;
    else                   cs_x = cr_x;
    if (cr_z[UW-1])        cs_z = '0;
    else if (cr_z > lim_z) cs_z = lim_z;
    else                   cs_z = cr_z;
  end

  assign col_c = cs_x[CLW-1:0];
  assign row_c = cs_z[CLW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.cell_off) begin
      col_q <= col_c;
      row_q <= row_c;
      dx_q  <= XW'(ux_q) - $signed(XW'(col_c) << FractionBits);
      dz_q  <= XW'(uz_q) - $signed(XW'(row_c) << FractionBits);
    end
  end

  // height store
  logic [AW-1:0]       base_q, rd_addr, ram_addr;
  logic                ram_we;
  logic [HEIGHT_W-1:0] ram_rdata;

  always_ff @(posedge clk_i) begin
    if (cmd_i.addr_calc) begin
      base_q <= AW'(row_q) * AW'(cols_c) + AW'(col_q);
    end
  end

  always_comb begin
    case (cmd_i.corner)
      CORNER_A: rd_addr = base_q;
      CORNER_B: rd_addr = base_q + AW'(1);
      CORNER_C: rd_addr = base_q + AW'(cols_c);
      CORNER_D: rd_addr = base_q + AW'(cols_c) + AW'(1);
      default:  rd_addr = base_q;
    endcase
  end

  assign ram_we   = cmd_i.wr_en && (32'(vidx_q) < Depth);
  assign ram_addr = cmd_i.wr_en ? AW'(vidx_q) : rd_addr;

  hmtq_ram #(
    .Width(HEIGHT_W),
    .Depth(Depth)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(vh_q),
    .rdata_o(ram_rdata)
  );

  // corner capture, in the cycle after the read
  logic                       rd_en_q;
  corner_e                    corner_q;
  logic signed [HEIGHT_W-1:0] h_a_q, h_b_q, h_c_q, h_d_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_en_q  <= 1'b0;
      corner_q <= CORNER_A;
    end else begin
      rd_en_q  <= cmd_i.rd_en;
      corner_q <= cmd_i.corner;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_q) begin
      case (corner_q)
        CORNER_A: h_a_q <= $signed(ram_rdata);
        CORNER_B: h_b_q <= $signed(ram_rdata);
        CORNER_C: h_c_q <= $signed(ram_rdata);
        CORNER_D: h_d_q <= $signed(ram_rdata);
        default: ;
      endcase
    end
  end

  // triangle setup and multiply-accumulate
  logic                 upper;
  logic signed [EW-1:0] e1_q, e2_q, e_sel;
  logic signed [MW-1:0] m1_q, m2_q, m_sel;
  logic signed [L:0]    m_lo;
  logic signed [HW-1:0] m_hi;
  logic signed [EW+L:0] p_lo;
  logic signed [EW+HW-1:0] p_hi;
  logic signed [SW-1:0] prod_q, acc_q;
  logic                 mul_en_q;
  logic                 step_hi;

  assign upper = ((XW + 1)'(dx_q) + (XW + 1)'(dz_q)) < OneSum;

  always_comb begin
    case (cmd_i.mul_step)
      MUL_E1_LO: begin e_sel = e1_q; m_sel = m1_q; step_hi = 1'b0; end
      MUL_E1_HI: begin e_sel = e1_q; m_sel = m1_q; step_hi = 1'b1; end
      MUL_E2_LO: begin e_sel = e2_q; m_sel = m2_q; step_hi = 1'b0; end
      MUL_E2_HI: begin e_sel = e2_q; m_sel = m2_q; step_hi = 1'b1; end
      default:   begin e_sel = e1_q; m_sel = m1_q; step_hi = 1'b0; end
    endcase
  end

  assign m_lo = $signed({1'b0, m_sel[L-1:0]});
  assign m_hi = m_sel[MW-1:L];
  assign p_lo = e_sel * m_lo;
  assign p_hi = e_sel * m_hi;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_en_q <= 1'b0;
    end else begin
      mul_en_q <= cmd_i.mul_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.tri_setup) begin
      if (upper) begin
        e1_q  <= EW'(h_b_q) - EW'(h_a_q);
        e2_q  <= EW'(h_c_q) - EW'(h_a_q);
        m1_q  <= MW'(dx_q);
        m2_q  <= MW'(dz_q);
        acc_q <= SW'(h_a_q) <<< FractionBits;
      end else begin
        e1_q  <= EW'(h_c_q) - EW'(h_d_q);
        e2_q  <= EW'(h_b_q) - EW'(h_d_q);
        m1_q  <= OneM - MW'(dx_q);
        m2_q  <= OneM - MW'(dz_q);
        acc_q <= SW'(h_d_q) <<< FractionBits;
      end
    end else if (mul_en_q) begin
      acc_q <= acc_q + prod_q;
    end
    if (cmd_i.mul_en) begin
      prod_q <= step_hi ? (SW'(p_hi) <<< L) : SW'(p_lo);
    end
  end

  // round half up, saturate, output register
  logic signed [SW-1:0]       rsum, rsh;
  logic signed [HEIGHT_W-1:0] h_q;

  assign rsum = acc_q + Half;
  assign rsh  = rsum >>> FractionBits;

  always_ff @(posedge clk_i) begin
    if (cmd_i.round) begin
      if (rsh > HMax)      h_q <= HMax[HEIGHT_W-1:0];
      else if (rsh < HMin) h_q <= HMin[HEIGHT_W-1:0];
      else                 h_q <= rsh[HEIGHT_W-1:0];
    end
    if (cmd_i.out_load) begin
      height_o <= h_q;
    end
  end

  assign status_o.div_done = (cnt_q == '0);
  assign status_o.is_query = (kind_q == KIND_QUERY);

endmodule

`default_nettype wire

### hw/rtl/heightmap_triangle_height_query.sv
// Top level of the heightmap triangle height query block.
// Depends on hmtq_pkg, hmtq_ctrl, hmtq_dp (which holds hmtq_ram).
`default_nettype none

//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid_i/in_ready_o, kind, index, pos   | word in
//  out     | out_valid_o/out_ready_i, height_o         | word out
//  cfg     | cfg_valid_i/cfg_ready_o, index, data      | word in
//
// A write word goes IDLE, DISPATCH, back to IDLE before the next acceptance.
// A query word runs the bit-serial divider by cell_size (CW being the
// coordinate width), then the four corner reads through the single store
// port, triangle setup, the multiply steps, rounding and the output load.
// Reset clears the FSM, the output valid and the registers (256, 256, 1);
// the height store has no reset and must be written before it is read.
// A result waits in the output register; the next word is accepted meanwhile
// and only the final load of a later query stalls until out is taken.

module heightmap_triangle_height_query import hmtq_pkg::*; #(
  parameter int MaxGridDim   = MAX_GRID_DIM_DEF,
  parameter int FractionBits = FRACTION_BITS_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic                       kind_i,
  input  wire logic [VIDX_W-1:0]          vertex_index_i,
  input  wire logic signed [HEIGHT_W-1:0] vertex_height_i,
  input  wire logic signed [POS_W-1:0]    pos_x_i,
  input  wire logic signed [POS_W-1:0]    pos_z_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic signed [HEIGHT_W-1:0]      height_o,
  input  wire logic                       cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]       cfg_index_i,
  input  wire logic [CFG_W-1:0]           cfg_data_i
);

  cmd_t    cmd;
  status_t status;

  // registers always writable; writes must come only while idle, unenforced
  assign cfg_ready_o = 1'b1;

  hmtq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  hmtq_dp #(
    .MaxGridDim  (MaxGridDim),
    .FractionBits(FractionBits)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .kind_i         (kind_i),
    .vertex_index_i (vertex_index_i),
    .vertex_height_i(vertex_height_i),
    .pos_x_i        (pos_x_i),
    .pos_z_i        (pos_z_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .height_o       (height_o)
  );

endmodule

`default_nettype wire

### verif/heightmap_triangle_height_query_tb.sv
// Self-checking testbench for the heightmap triangle height query block.
// Drives write and query words, predicts each height, checks the results.
// Depends on hmtq_pkg and heightmap_triangle_height_query.
`timescale 1ns / 1ps

module heightmap_triangle_height_query_tb;
  import hmtq_pkg::*;

  localparam int FRAC       = FRACTION_BITS_DEF;
  localparam int DEPTH      = MAX_GRID_DIM_DEF * MAX_GRID_DIM_DEF;
  localparam int QUERY_LAT  = 60;      // a query's whole run, with margin on top
  localparam int CYCLE_CAP  = 1000000;
  localparam longint H_MAX  = 8388607;
  localparam longint H_MIN  = -8388608;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                       in_valid_i = 1'b0;
  logic                       in_ready_o;
  logic                       kind_i = KIND_WRITE;
  logic [VIDX_W-1:0]          vertex_index_i = '0;
  logic signed [HEIGHT_W-1:0] vertex_height_i = '0;
  logic signed [POS_W-1:0]    pos_x_i = '0;
  logic signed [POS_W-1:0]    pos_z_i = '0;
  logic                       out_valid_o;
  logic                       out_ready_i = 1'b0;
  logic signed [HEIGHT_W-1:0] height_o;
  logic                       cfg_valid_i = 1'b0;
  logic                       cfg_ready_o;
  logic [CFG_IDX_W-1:0]       cfg_index_i = CFG_GRID_COLUMNS;
  logic [CFG_W-1:0]           cfg_data_i = '0;

  heightmap_triangle_height_query dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .kind_i         (kind_i),
    .vertex_index_i (vertex_index_i),
    .vertex_height_i(vertex_height_i),
    .pos_x_i        (pos_x_i),
    .pos_z_i        (pos_z_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .height_o       (height_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow state: register copies and the vertex height grid
  // ---------------------------------------------------------------------------
  logic [DIM_W-1:0]           shadow_cols;
  logic [DIM_W-1:0]           shadow_rows;
  logic [SIZE_W-1:0]          shadow_size;
  logic signed [HEIGHT_W-1:0] shadow_grid [DEPTH];

  logic signed [HEIGHT_W-1:0] pending_heights [$];  // heights still owed by the block
  int  error_count = 0;
  bit  calm = 1'b0;        // no idling on either side while set
  int  hold_cycles = 0;    // receiver back-pressure stretch, counted down below

  function automatic longint floor_div(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q--;
    return q;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint eff_cols();
    return clamp(longint'(shadow_cols), 2, MAX_GRID_DIM_DEF);
  endfunction

  function automatic longint eff_rows();
    return clamp(longint'(shadow_rows), 2, MAX_GRID_DIM_DEF);
  endfunction

  function automatic longint eff_size();
    return shadow_size == 0 ? 1 : longint'(shadow_size);
  endfunction

  // Interpolated height for a query at the current settings.
  function automatic logic signed [HEIGHT_W-1:0] interp_height(
      logic signed [POS_W-1:0] px, logic signed [POS_W-1:0] pz);
    longint one, cols, rows, size, cx, cz, ux, uz, col, row, dx, dz;
    longint a, b, c, d, s, h;
    one  = longint'(1) << FRAC;
    cols = eff_cols();
    rows = eff_rows();
    size = eff_size();
    cx = (cols - 1) * size * (one / 2) + longint'(px);
    cz = (rows - 1) * size * (one / 2) - longint'(pz);
    ux = floor_div(cx, size);
    uz = floor_div(cz, size);
    col = clamp(floor_div(ux, one), 0, cols - 2);
    row = clamp(floor_div(uz, one), 0, rows - 2);
    dx = ux - col * one;
    dz = uz - row * one;
    a = shadow_grid[row * cols + col];
    b = shadow_grid[row * cols + col + 1];
    c = shadow_grid[(row + 1) * cols + col];
    d = shadow_grid[(row + 1) * cols + col + 1];
    // upper triangle ABC, else lower triangle DCB
    if (dx + dz < one) s = a * one + (b - a) * dx + (c - a) * dz;
    else               s = d * one + (c - d) * (one - dx) + (b - d) * (one - dz);
    h = clamp(floor_div(s + one / 2, one), H_MIN, H_MAX);
    return h[HEIGHT_W-1:0];
  endfunction

  function automatic int gap_len();
    if (calm || $urandom_range(0, 99) >= 32) return 0;
    return $urandom_range(1, 4);
  endfunction

  // ---------------------------------------------------------------------------
  // Input channel: one word per call, entered and left at a rising edge
  // ---------------------------------------------------------------------------
  task automatic send_word(logic kind, logic [VIDX_W-1:0] idx,
                           logic signed [HEIGHT_W-1:0] hgt,
                           logic signed [POS_W-1:0] px, logic signed [POS_W-1:0] pz,
                           bit known, logic signed [HEIGHT_W-1:0] known_height);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    kind_i          <= kind;
    vertex_index_i  <= idx;
    vertex_height_i <= hgt;
    pos_x_i         <= px;
    pos_z_i         <= pz;
    do @(posedge clk_i); while (!in_ready_o);
    if (kind == KIND_QUERY)
      pending_heights.insert(pending_heights.size(),
                             known ? known_height : interp_height(px, pz));
    else
      shadow_grid[idx] = hgt;
  endtask

  // Waits out every owed result plus the query latency, with the input idle.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_heights.size() != 0) @(posedge clk_i);
    repeat (QUERY_LAT) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_GRID_COLUMNS: shadow_cols = data[DIM_W-1:0];
      CFG_GRID_ROWS:    shadow_rows = data[DIM_W-1:0];
      CFG_CELL_SIZE:    shadow_size = data[SIZE_W-1:0];
      default: ;        // unused index, ignored by the block
    endcase
  endtask

  task automatic configure(logic [CFG_W-1:0] cols, logic [CFG_W-1:0] rows,
                           logic [CFG_W-1:0] size);
    drain();
    write_reg(CFG_GRID_COLUMNS, cols);
    write_reg(CFG_GRID_ROWS, rows);
    write_reg(CFG_CELL_SIZE, size);
  endtask

  function automatic logic signed [HEIGHT_W-1:0] rand_height();
    case ($urandom_range(0, 3))
      0:       return HEIGHT_W'($urandom());                       // full range
      1:       return $urandom_range(0, 1) ? HEIGHT_W'(H_MAX) : HEIGHT_W'(H_MIN);
      default: return HEIGHT_W'(int'($urandom_range(0, 8191)) - 4096);
    endcase
  endfunction

  // Loads every vertex of the active grid so no query reads an empty entry.
  task automatic load_grid();
    for (int i = 0; i < eff_cols() * eff_rows(); i++)
      send_word(KIND_WRITE, i[VIDX_W-1:0], rand_height(), $urandom(), $urandom(), 0, '0);
  endtask

  function automatic logic signed [POS_W-1:0] rand_pos(longint extent);
    longint span;
    span = extent + 2 * eff_size() * (longint'(1) << FRAC);
    if ($urandom_range(0, 4) == 0) return $urandom();    // far outside: extrapolation
    return POS_W'(longint'($urandom_range(0, 32'(2 * span))) - span);
  endfunction

  task automatic random_words(int count);
    longint half_x, half_z;
    half_x = (eff_cols() - 1) * eff_size() * (longint'(1) << (FRAC - 1));
    half_z = (eff_rows() - 1) * eff_size() * (longint'(1) << (FRAC - 1));
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 99) < 70) begin
        send_word(KIND_QUERY, VIDX_W'($urandom()), HEIGHT_W'($urandom()),
                  rand_pos(half_x), rand_pos(half_z), 0, '0);
      end else if ($urandom_range(0, 4) != 0) begin
        send_word(KIND_WRITE,
                  VIDX_W'($urandom_range(0, 32'(eff_cols() * eff_rows() - 1))),
                  rand_height(), $urandom(), $urandom(), 0, '0);
      end else begin
        // anywhere in the store; only grid entries are ever read back
        send_word(KIND_WRITE, VIDX_W'($urandom()), rand_height(), $urandom(), $urandom(),
                  0, '0);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Directed words on a 2x2 grid of unit cells
  // ---------------------------------------------------------------------------
  typedef struct {
    logic                       kind;
    logic [VIDX_W-1:0]          idx;
    logic signed [HEIGHT_W-1:0] hgt;
    logic signed [POS_W-1:0]    px;
    logic signed [POS_W-1:0]    pz;
    bit                         known;
    logic signed [HEIGHT_W-1:0] known_height;
  } stim_row_t;

  localparam logic signed [POS_W-1:0] P_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [POS_W-1:0] P_MIN = 32'sh8000_0000;
  localparam logic signed [HEIGHT_W-1:0] HT_MAX = 24'sh7F_FFFF;
  localparam logic signed [HEIGHT_W-1:0] HT_MIN = 24'sh80_0000;

  stim_row_t directed [] = '{
    // flat top grid: every query answers the stored height exactly
    '{KIND_WRITE, 16'd0, HT_MAX, 0, 0, 0, 0},
    '{KIND_WRITE, 16'd1, HT_MAX, 0, 0, 0, 0},
    '{KIND_WRITE, 16'd2, HT_MAX, 0, 0, 0, 0},
    '{KIND_WRITE, 16'd3, HT_MAX, 0, 0, 0, 0},
    '{KIND_QUERY, 16'd0, 0, 0,     0,     1, HT_MAX},
    '{KIND_QUERY, 16'hFFFF, 0, P_MAX, P_MIN, 1, HT_MAX},
    '{KIND_QUERY, 16'd0, 0, P_MIN, P_MAX, 1, HT_MAX},
    // top of the store, outside the grid
    '{KIND_WRITE, 16'hFFFF, 24'sh0, 0, 0, 0, 0},
    // sloped grid: both triangles, extrapolation and saturation
    '{KIND_WRITE, 16'd0, HT_MIN, 0, 0, 0, 0},
    '{KIND_WRITE, 16'd1, HT_MAX, 0, 0, 0, 0},
    '{KIND_WRITE, 16'd2, 24'sh0, 0, 0, 0, 0},
    '{KIND_WRITE, 16'd3, -24'sd1, 0, 0, 0, 0},
    '{KIND_QUERY, 16'd0, 0, 0,     0,     0, 0},
    '{KIND_QUERY, 16'd0, 0, -128,  128,   0, 0},   // corner A
    '{KIND_QUERY, 16'd0, 0, 128,   -128,  0, 0},   // corner D
    '{KIND_QUERY, 16'd0, 0, 64,    64,    0, 0},   // on the diagonal
    '{KIND_QUERY, 16'd0, 0, 63,    64,    0, 0},   // just inside upper
    '{KIND_QUERY, 16'd0, 0, P_MAX, 0,     0, 0},   // lower triangle, far extrapolation
    '{KIND_QUERY, 16'd0, 0, P_MIN, 0,     0, 0},   // saturates low
    '{KIND_QUERY, 16'd0, 0, 0,     P_MAX, 0, 0},
    '{KIND_QUERY, 16'd0, 0, P_MAX, P_MAX, 0, 0},
    '{KIND_QUERY, 16'd0, 0, P_MIN, P_MIN, 0, 0},
    '{KIND_QUERY, 16'd0, 0, -1,    -1,    0, 0}
  };

  // ---------------------------------------------------------------------------
  // Output channel: check accepted heights, then pick the next ready
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_heights.size() == 0) begin
        $display("%0t: height %0d with none owed", $time, height_o);
        error_count++;
      end else begin
        logic signed [HEIGHT_W-1:0] owed;
        owed = pending_heights.pop_front();
        if (height_o !== owed) begin
          $display("%0t: height expected %0d actual %0d", $time, owed, height_o);
          error_count++;
        end
      end
    end
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= calm || ($urandom_range(0, 99) >= 32);
    end
  end

  int cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_CAP) begin
      $display("heightmap_triangle_height_query: mismatch");
      $finish;
    end
  end

  initial begin
    foreach (shadow_grid[i]) shadow_grid[i] = '0;
    shadow_cols = GRID_COLUMNS_RST;
    shadow_rows = GRID_ROWS_RST;
    shadow_size = CELL_SIZE_RST;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    configure(11'd2, 11'd2, 11'd1);
    write_reg(2'd3, 11'h7FF);             // unused index: no effect
    foreach (directed[i])
      send_word(directed[i].kind, directed[i].idx, directed[i].hgt, directed[i].px,
                directed[i].pz, directed[i].known, directed[i].known_height);

    // wide grid, cells of size 1024
    configure(11'd24, 11'd2, 11'd1024);
    load_grid();
    random_words(60);

    // tall grid, unit cells, no idling on either side
    configure(11'd2, 11'd16, 11'd1);
    calm = 1'b1;
    load_grid();
    random_words(50);
    calm = 1'b0;

    // upper data bits ignored; largest cell size
    configure(11'h603, 11'd4, 11'h7FF);
    load_grid();
    random_words(30);
    drain();                              // sender pauses until all heights are back
    random_words(30);

    // column count below range and zero cell size
    configure(11'd0, 11'd9, 11'd0);
    load_grid();
    random_words(40);

    // long receiver stall while words keep coming
    configure(11'd9, 11'd6, 11'd7);
    load_grid();
    hold_cycles = 400;
    random_words(50);

    in_valid_i <= 1'b0;
    while (pending_heights.size() != 0) @(posedge clk_i);
    repeat (QUERY_LAT) @(posedge clk_i);
    if (error_count == 0)
      $display("heightmap_triangle_height_query: match");
    else
      $display("heightmap_triangle_height_query: mismatch");
    $finish;
  end

endmodule
